// ===== rtl/dlrd_pkg.sv =====
// ----------------------------------------------------------------------------
// dlrd_pkg: shared definitions for the dose log record decoder
// Record kinds, tag byte codes and the logging interval table.
// ----------------------------------------------------------------------------
`default_nettype none

package dlrd_pkg;

  typedef enum logic [2:0] {
    KIND_IDLE      = 3'd0,
    KIND_SHORT     = 3'd1,
    KIND_LONG      = 3'd2,
    KIND_ABS_TIME  = 3'd3,
    KIND_ABS_COUNT = 3'd4
  } kind_e;

  // Number of interval codes in use, code zero included (range 2 to 6).
  localparam int unsigned INTERVAL_CODES = 6;

  localparam logic [7:0] TAG_LONG_DELTA = 8'hf0;
  localparam logic [7:0] TAG_INTERVAL   = 8'hf1;
  localparam logic [7:0] TAG_SESSION    = 8'hf8;
  localparam logic [7:0] TAG_PAGE_END   = 8'hff;

  localparam logic [3:0] ABS_FIELD_BYTES = 4'd4;

  // Logging interval in seconds for an interval code.
  function automatic logic [11:0] interval_of(input logic [3:0] code);
    logic [11:0] secs;
    case (code)
      4'd1:    secs = 12'd3600;
      4'd2:    secs = 12'd600;
      4'd3:    secs = 12'd60;
      4'd4:    secs = 12'd10;
      4'd5:    secs = 12'd1;
      default: secs = 12'd0;
    endcase
    return secs;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dose_log_record_decoder_top.sv =====
// ----------------------------------------------------------------------------
// dose_log_record_decoder_top: log byte stream to timed pulse-count records
// Parses stored log bytes, one per beat, and emits absolute time and count
// for each delta or absolute record, plus an end-of-data marker.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                                   tuser
//  s_axis    in   [7:0] data_byte                         [0] first_of_page
//                                                         [1] last_page
//  m_axis    out  [31:0] record_time,                     [0] new_session
//                 [63:32] record_pulse_count              [1] end_of_data
//
//  Each beat goes through the input register and the result register. One beat is
//  accepted per cycle while m_axis does not stall; a byte is decoded in a single pass of
//  logic from the input register and the parser state to the result register.
//  Reset clears the parser state, the interval, the time and the count.
//  A stall on m_axis holds the result register; the input register then holds too,
//  and s_axis_tready_o drops only while both are full.
//
`default_nettype none

module dose_log_record_decoder_top
  import dlrd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser_i,   // [0] first_of_page, [1] last_page
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // [31:0] record_time,
                                             // [63:32] record_pulse_count
  output logic [1:0]       m_axis_tuser_o    // [0] new_session, [1] end_of_data
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       in_last_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_time_q;
  logic [31:0] out_count_q;
  logic        out_session_q;
  logic        out_eod_q;

  // Parser state
  kind_e       kind_q, kind_d;
  logic [3:0]  left_q, left_d;
  logic [31:0] gather_q, gather_d;
  logic [31:0] held_q, held_d;
  logic [31:0] time_q, time_d;
  logic [31:0] count_q, count_d;
  logic [11:0] interval_q, interval_d;
  logic        session_q, session_d;
  logic        skip_q, skip_d;

  // Result of the current beat
  logic        res_valid;
  logic        res_session;
  logic        res_eod;

  logic        advance;

  // Working values
  kind_e       kind_w;
  logic [3:0]  left_w;
  logic        skip_w;
  logic [31:0] shifted;
  logic [3:0]  left_dec;
  logic [31:0] delta_v;
  logic [3:0]  code;
  logic        is_interval;

  // Move the input beat into decode when the result slot can take it.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign code        = in_byte_q[3:0];
  assign is_interval = (in_byte_q[7:4] == TAG_INTERVAL[7:4]) && (code != 4'd0) &&
                       ({28'd0, code} < INTERVAL_CODES[31:0]);

  always_comb begin
    kind_d      = kind_q;
    left_d      = left_q;
    gather_d    = gather_q;
    held_d      = held_q;
    time_d      = time_q;
    count_d     = count_q;
    interval_d  = interval_q;
    session_d   = session_q;
    skip_d      = skip_q;
    res_valid   = 1'b0;
    res_session = session_q;
    res_eod     = 1'b0;

    // A page start abandons any partial record and ends page skipping.
    kind_w  = in_first_q ? KIND_IDLE : kind_q;
    left_w  = in_first_q ? 4'd0 : left_q;
    skip_w  = in_first_q ? 1'b0 : skip_q;
    kind_d  = kind_w;
    left_d  = left_w;
    skip_d  = skip_w;

    shifted  = {gather_q[23:0], in_byte_q};
    left_dec = (left_w != 4'd0) ? left_w - 4'd1 : 4'd0;

    // Prefix-coded delta, sign extended from the payload bits.
    if (!in_byte_q[7]) begin
      delta_v = {{25{in_byte_q[6]}}, in_byte_q[6:0]};
    end else if (!in_byte_q[6]) begin
      delta_v = {{26{in_byte_q[5]}}, in_byte_q[5:0]};
    end else if (!in_byte_q[5]) begin
      delta_v = {{27{in_byte_q[4]}}, in_byte_q[4:0]};
    end else begin
      delta_v = {{28{in_byte_q[3]}}, in_byte_q[3:0]};
    end

    if (!skip_w) begin
      if (kind_w != KIND_IDLE) begin
        // Inside a record every byte is data.
        gather_d = shifted;
        left_d   = left_dec;
        if (left_dec == 4'd0) begin
          case (kind_w)
            KIND_ABS_TIME: begin
              held_d   = shifted;
              gather_d = 32'd0;
              kind_d   = KIND_ABS_COUNT;
              left_d   = ABS_FIELD_BYTES;
            end
            KIND_ABS_COUNT: begin
              kind_d    = KIND_IDLE;
              time_d    = held_q;
              count_d   = shifted;
              res_valid = 1'b1;
              session_d = 1'b0;
            end
            default: begin
              kind_d    = KIND_IDLE;
              time_d    = time_q + {20'd0, interval_q};
              count_d   = count_q + shifted;
              res_valid = 1'b1;
              session_d = 1'b0;
            end
          endcase
        end
      end else if (in_byte_q < TAG_LONG_DELTA) begin
        if (!in_byte_q[7]) begin
          time_d    = time_q + {20'd0, interval_q};
          count_d   = count_q + delta_v;
          res_valid = 1'b1;
          session_d = 1'b0;
        end else begin
          gather_d = delta_v;
          kind_d   = KIND_SHORT;
          if (!in_byte_q[6]) begin
            left_d = 4'd1;
          end else if (!in_byte_q[5]) begin
            left_d = 4'd2;
          end else begin
            left_d = 4'd3;
          end
        end
      end else if (in_byte_q == TAG_LONG_DELTA) begin
        gather_d = 32'd0;
        kind_d   = KIND_LONG;
        left_d   = ABS_FIELD_BYTES;
      end else if (is_interval) begin
        interval_d = interval_of(code);
        gather_d   = 32'd0;
        kind_d     = KIND_ABS_TIME;
        left_d     = ABS_FIELD_BYTES;
      end else if (in_byte_q == TAG_SESSION) begin
        session_d = 1'b1;
      end else if (in_byte_q == TAG_PAGE_END) begin
        if (in_last_q) begin
          // End of data: a marker result with zero payload.
          session_d   = 1'b0;
          res_valid   = 1'b1;
          res_session = 1'b0;
          res_eod     = 1'b1;
        end else begin
          skip_d = 1'b1;
        end
      end
      // Anything else is filler: drop it.
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i[0];
      in_last_q  <= s_axis_tuser_i[1];
    end
  end

  // Parser state, updated once per decoded beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= KIND_IDLE;
      left_q     <= 4'd0;
      gather_q   <= 32'd0;
      held_q     <= 32'd0;
      time_q     <= 32'd0;
      count_q    <= 32'd0;
      interval_q <= 12'd0;
      session_q  <= 1'b0;
      skip_q     <= 1'b0;
    end else if (advance) begin
      kind_q     <= kind_d;
      left_q     <= left_d;
      gather_q   <= gather_d;
      held_q     <= held_d;
      time_q     <= time_d;
      count_q    <= count_d;
      interval_q <= interval_d;
      session_q  <= session_d;
      skip_q     <= skip_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_time_q    <= res_eod ? 32'd0 : time_d;
      out_count_q   <= res_eod ? 32'd0 : count_d;
      out_session_q <= res_session;
      out_eod_q     <= res_eod;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_count_q, out_time_q};
  assign m_axis_tuser_o  = {out_eod_q, out_session_q};

  // An end-of-data marker carries no time, count or session flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> (m_axis_tdata_o == 64'd0) && !m_axis_tuser_o[0])
    else $error("end-of-data result with nonzero payload");

  // Idle parser has nothing left to gather; an open record has 1 to 4 bytes left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == KIND_IDLE) == (left_q == 4'd0))
    else $error("record kind and byte count disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= ABS_FIELD_BYTES)
    else $error("byte count beyond a four-byte field");

  // Page skipping starts only from outside a record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> kind_q == KIND_IDLE)
    else $error("page skip with an open record");

endmodule

`default_nettype wire

// ===== test/dose_log_record_checker.sv =====
// ----------------------------------------------------------------------------
// dose_log_record_checker: predicts and checks decoded log records
// Watches both streams of the decoder. Each accepted log byte runs through a
// behavioral copy of the parser, and each output beat is compared field by
// field with the oldest predicted record.
// ----------------------------------------------------------------------------
module dose_log_record_checker
  import dlrd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser_i,   // [0] first_of_page, [1] last_page
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [63:0] m_axis_tdata_i,   // [31:0] record_time,
                                             // [63:32] record_pulse_count
  input  wire logic [1:0]  m_axis_tuser_i,   // [0] new_session, [1] end_of_data
  output int               mismatches_o,
  output int               pending_o,
  output int               records_o,
  output int               end_marks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 20;
  // Interval table holds codes 0 to 5.
  localparam int TABLE_CODES = 6;

  typedef struct packed {
    logic [31:0] rec_time;
    logic [31:0] pulse_count;
    logic        session;
    logic        end_mark;
  } log_record_t;

  log_record_t expected_records[$];

  // Parser state
  kind_e       rec_kind;
  logic [3:0]  bytes_to_go;
  logic [31:0] gather;
  logic [31:0] abs_time_hold;
  logic [31:0] log_time;
  logic [31:0] log_count;
  logic [11:0] interval_s;
  logic        session_flag;
  logic        skipping;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    records_o    = 0;
    end_marks_o  = 0;
  end

  function automatic logic [11:0] seconds_per_tick(input logic [7:0] tag);
    logic [7:0]  code;
    logic [11:0] secs;
    code = tag - TAG_LONG_DELTA;
    case (code)
      8'd1:    secs = 12'(60 * 60);
      8'd2:    secs = 12'(10 * 60);
      8'd3:    secs = 12'(1 * 60);
      8'd4:    secs = 12'd10;
      8'd5:    secs = 12'd1;
      default: secs = 12'd0;
    endcase
    return secs;
  endfunction

  task automatic emit_record(input logic eod);
    log_record_t rec;
    if (eod) begin
      rec = '{rec_time: 32'd0, pulse_count: 32'd0, session: 1'b0, end_mark: 1'b1};
    end else begin
      rec = '{rec_time: log_time, pulse_count: log_count, session: session_flag,
              end_mark: 1'b0};
    end
    session_flag = 1'b0;
    expected_records.push_back(rec);
  endtask

  task automatic apply_delta(input logic [31:0] delta);
    log_time  = log_time + {20'd0, interval_s};
    log_count = log_count + delta;
    emit_record(1'b0);
  endtask

  task automatic decode_log_byte(input logic [7:0] b, input logic first, input logic last);
    logic [31:0] delta;
    logic [3:0]  size;
    if (first) begin
      skipping    = 1'b0;
      rec_kind    = KIND_IDLE;
      bytes_to_go = 4'd0;
    end
    if (skipping) begin
      // drop everything until the next page start
    end else if (rec_kind != KIND_IDLE) begin
      gather = {gather[23:0], b};
      if (bytes_to_go != 4'd0) bytes_to_go = bytes_to_go - 4'd1;
      if (bytes_to_go == 4'd0) begin
        case (rec_kind)
          KIND_ABS_TIME: begin
            abs_time_hold = gather;
            gather        = 32'd0;
            rec_kind      = KIND_ABS_COUNT;
            bytes_to_go   = ABS_FIELD_BYTES;
          end
          KIND_ABS_COUNT: begin
            rec_kind  = KIND_IDLE;
            log_time  = abs_time_hold;
            log_count = gather;
            emit_record(1'b0);
          end
          default: begin
            rec_kind = KIND_IDLE;
            apply_delta(gather);
          end
        endcase
      end
    end else if (b < TAG_LONG_DELTA) begin
      // length prefix, then a sign-extended head of the delta
      casez (b)
        8'b0???????: begin size = 4'd1; delta = {{25{b[6]}}, b[6:0]}; end
        8'b10??????: begin size = 4'd2; delta = {{26{b[5]}}, b[5:0]}; end
        8'b110?????: begin size = 4'd3; delta = {{27{b[4]}}, b[4:0]}; end
        default:     begin size = 4'd4; delta = {{28{b[3]}}, b[3:0]}; end
      endcase
      if (size == 4'd1) begin
        apply_delta(delta);
      end else begin
        gather      = delta;
        rec_kind    = KIND_SHORT;
        bytes_to_go = size - 4'd1;
      end
    end else if (b == TAG_LONG_DELTA) begin
      gather      = 32'd0;
      rec_kind    = KIND_LONG;
      bytes_to_go = ABS_FIELD_BYTES;
    end else if (b >= TAG_INTERVAL && b < TAG_LONG_DELTA + INTERVAL_CODES &&
                 b < TAG_LONG_DELTA + TABLE_CODES) begin
      interval_s  = seconds_per_tick(b);
      gather      = 32'd0;
      rec_kind    = KIND_ABS_TIME;
      bytes_to_go = ABS_FIELD_BYTES;
    end else if (b == TAG_SESSION) begin
      session_flag = 1'b1;
    end else if (b != TAG_PAGE_END) begin
      // filler and unused interval codes
    end else if (last) begin
      emit_record(1'b1);
    end else begin
      skipping = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches_o < PRINT_LIMIT)
      $display("%0t ns: mismatch in %s: got %h, want %h", $time, what, got, want);
    mismatches_o++;
  endtask

  task automatic check_result();
    log_record_t want;
    if (expected_records.size() == 0) begin
      report_mismatch("unexpected beat, record_time", m_axis_tdata_i[31:0], 32'd0);
    end else begin
      want = expected_records.pop_front();
      if (m_axis_tdata_i[31:0] !== want.rec_time)
        report_mismatch("record_time", m_axis_tdata_i[31:0], want.rec_time);
      if (m_axis_tdata_i[63:32] !== want.pulse_count)
        report_mismatch("record_pulse_count", m_axis_tdata_i[63:32], want.pulse_count);
      if (m_axis_tuser_i[0] !== want.session)
        report_mismatch("new_session", {31'd0, m_axis_tuser_i[0]}, {31'd0, want.session});
      if (m_axis_tuser_i[1] !== want.end_mark)
        report_mismatch("end_of_data", {31'd0, m_axis_tuser_i[1]}, {31'd0, want.end_mark});
      if (want.end_mark) end_marks_o++;
      else records_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_kind      = KIND_IDLE;
      bytes_to_go   = 4'd0;
      gather        = 32'd0;
      abs_time_hold = 32'd0;
      log_time      = 32'd0;
      log_count     = 32'd0;
      interval_s    = 12'd0;
      session_flag  = 1'b0;
      skipping      = 1'b0;
      expected_records.delete();
      pending_o <= 0;
    end else begin
      // results come from registered inputs, so check before predicting
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
      if (s_axis_tvalid_i && s_axis_tready_i)
        decode_log_byte(s_axis_tdata_i, s_axis_tuser_i[0], s_axis_tuser_i[1]);
      pending_o <= expected_records.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the dose log record decoder
// Feeds directed and random log byte streams with bursty input and a
// patterned output stall, and leaves prediction and checking to the
// record checker instantiated beside the decoder.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dlrd_pkg::*;

  localparam int RANDOM_BYTES    = 1800;
  localparam int IDLE_LIMIT      = 4000;  // well above the longest correct quiet stretch
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER  = 500;   // beats sent before the long hold-off
  localparam int DRAIN_CYCLES    = 16;
  localparam logic [7:0] FILLER_LAST = 8'hfe;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } log_byte_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic [1:0]  s_tuser  = 2'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;

  int mismatches;
  int pending;
  int records;
  int end_marks;
  int beats_sent  = 0;
  int idle_cycles = 0;

  // Byte stream and the page state used to build it
  log_byte_t stream[$];
  int        page_left    = 0;
  logic      page_is_last = 1'b0;
  int        skipped_bytes = 0;

  always #1 clk_i = ~clk_i;

  dose_log_record_decoder_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  dose_log_record_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .records_o       (records),
    .end_marks_o     (end_marks)
  );

  // Append a byte with explicit page flags.
  task automatic put_fixed(input logic [7:0] b, input logic first, input logic last);
    stream.push_back({b, first, last});
  endtask

  // Append a byte inside the running page; open a new page when it is used up.
  task automatic put_byte(input logic [7:0] b);
    logic first;
    first = (page_left == 0);
    if (first) begin
      page_left    = $urandom_range(8, 64);
      page_is_last = ($urandom_range(0, 3) == 0);
    end
    page_left--;
    stream.push_back({b, first, page_is_last});
  endtask

  task automatic put_random_bytes(input int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  // Append one random record, tag or piece of noise.
  task automatic add_random_item();
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      n = $urandom_range(1, 4);
      case (n)
        1:       put_byte({1'b0, 7'($urandom)});
        2:       put_byte({2'b10, 6'($urandom)});
        3:       put_byte({3'b110, 5'($urandom)});
        default: put_byte({4'b1110, 4'($urandom)});
      endcase
      put_random_bytes(n - 1);
    end else if (pick < 55) begin
      put_byte(TAG_LONG_DELTA);
      put_random_bytes(4);
    end else if (pick < 67) begin
      put_byte(TAG_LONG_DELTA + 8'($urandom_range(1, 5)));
      put_random_bytes(8);
    end else if (pick < 75) begin
      put_byte(TAG_SESSION);
    end else if (pick < 82) begin
      // filler: unused interval codes and the spare tags, never the session tag
      b = 8'($urandom_range(8'hf6, 8'hfd));
      if (b >= TAG_SESSION) b = b + 8'd1;
      put_byte(b);
    end else if (pick < 90) begin
      put_byte(TAG_PAGE_END);
      if (!page_is_last) begin
        // rest of the page is dead; jump to the next page
        n = $urandom_range(0, 5);
        put_random_bytes(n);
        skipped_bytes += n;
        page_left = 0;
      end
    end else begin
      // noise with random page flags
      put_fixed(8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: switch among stall patterns, with one long hold-off to back up
  // the decoder while the sender keeps offering bytes.
  initial begin : result_receiver
    int hold_left;
    int mode;
    int mode_left;
    int phase;
    bit held_once;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    held_once = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held_once && beats_sent >= HOLD_OFF_AFTER) begin
        held_once = 1;
        hold_left = HOLD_OFF_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  // Sender: build the stream, release reset, then drive it in bursts.
  initial begin : byte_sender
    int idx;
    int burst;
    int gap;
    int k;
    int directed_bytes;

    // Directed opening: session flag on the first record, the delta extremes,
    // an abandoned record at a page start, the long delta, an absolute record
    // with extreme time and count, filler, end of data and a page skip.
    put_fixed(TAG_SESSION, 1'b1, 1'b0);
    put_fixed(8'h7f, 1'b0, 1'b0);              // delta -1
    put_fixed(8'hc0, 1'b0, 1'b0);              // three-byte record, cut off
    put_fixed(8'h12, 1'b0, 1'b0);
    put_fixed(8'h40, 1'b1, 1'b0);              // page start, delta -64
    put_fixed(8'hef, 1'b0, 1'b0);              // four-byte record, all ones
    repeat (3) put_fixed(8'hff, 1'b0, 1'b0);
    put_fixed(TAG_LONG_DELTA, 1'b0, 1'b0);     // most negative long delta
    put_fixed(8'h80, 1'b0, 1'b0);
    repeat (3) put_fixed(8'h00, 1'b0, 1'b0);
    put_fixed(TAG_LONG_DELTA + 8'd5, 1'b0, 1'b0);  // 1 s interval
    repeat (4) put_fixed(8'hff, 1'b0, 1'b0);
    repeat (4) put_fixed(8'h00, 1'b0, 1'b0);
    put_fixed(8'h00, 1'b0, 1'b0);              // delta 0, time advances
    put_fixed(FILLER_LAST, 1'b0, 1'b0);
    put_fixed(TAG_PAGE_END, 1'b0, 1'b1);       // end of data
    put_fixed(TAG_PAGE_END, 1'b0, 1'b0);       // skip the rest of the page
    put_fixed(8'h55, 1'b0, 1'b0);              // ignored
    put_fixed(8'h3f, 1'b1, 1'b1);              // parsed again at the new page
    directed_bytes = stream.size();

    page_left = 0;
    while (stream.size() - skipped_bytes < directed_bytes + RANDOM_BYTES) add_random_item();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idx = 0;
    while (idx < stream.size()) begin
      burst = $urandom_range(1, 48);
      gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      for (k = 0; k < burst && idx < stream.size(); k++) begin
        s_tvalid <= 1'b1;
        s_tdata  <= stream[idx].data;
        s_tuser  <= {stream[idx].last, stream[idx].first};
        // hold the beat until the decoder takes it
        @(posedge clk_i);
        while (!s_tready) @(posedge clk_i);
        idx++;
        beats_sent = idx;
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every predicted record, then keep watching for strays.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d log bytes; checked %0d records and %0d end-of-data beats.",
             beats_sent, records, end_marks);
    $display("Covered page skips, records cut by page starts and a %0d-cycle output stall.",
             HOLD_OFF_CYCLES);
    if (pending != 0) $display("%0d predicted records never came out", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
